FILE: rtl/core/polynomial_derivative_evaluator_assert.svh
// Assertion macros used by the polynomial derivative evaluator checker
`ifndef POLYNOMIAL_DERIVATIVE_EVALUATOR_ASSERT_SVH
`define POLYNOMIAL_DERIVATIVE_EVALUATOR_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low
`define PDE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("polynomial derivative evaluator check failed");

// Next-cycle implication, clocked on clk, off while rst_n is low
`define PDE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("polynomial derivative evaluator check failed");

`endif

FILE: rtl/core/pde_pkg.sv
// Types, constants and helper functions of the polynomial derivative evaluator
`default_nettype none

package pde_pkg;

    // Field widths
    localparam int PT_W     = 32;   // abscissa, Q16.16
    localparam int ORD_W    = 3;    // derivative order
    localparam int COEF_W   = 32;   // coefficient, Q16.16
    localparam int TC_W     = 3;    // term count
    localparam int VAL_W    = 48;   // result, Q32.16

    // Coefficient storage: seven registers, slot seven reads as zero
    localparam int NUM_COEF   = 7;
    localparam int COEF_SLOTS = 8;

    // Datapath widths
    localparam int FF_W     = 10;                    // falling factorial, max 720
    localparam int D_W      = COEF_W + FF_W + 1;     // scaled coefficient
    localparam int SPLIT    = 24;                    // acc split point for partial products
    localparam int LO_PP_W  = SPLIT + 1 + PT_W;      // low partial product
    localparam int HI_PP_W  = VAL_W - SPLIT + PT_W;  // high partial product
    localparam int PROD_W   = 80;                    // full product plus rounding
    localparam int SUM_W    = VAL_W + 1;             // accumulate sum before clipping

    // Pipeline stages in one Horner step
    localparam int STEP_STAGES = 4;

    // Configuration port
    localparam int CFG_AW = 5;
    localparam int CFG_DW = 32;
    localparam int IDX_W  = 3;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_COEFF_0    = 3'd0;
    localparam logic [IDX_W-1:0] REG_TERM_COUNT = 3'd7;

    // Output limits
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef struct packed {
        logic signed [PT_W-1:0] point;
        logic [ORD_W-1:0]       derivative_order;
    } pde_in_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    saturated;
    } pde_out_t;

    // Configuration seen by the Horner steps
    typedef struct packed {
        logic [COEF_SLOTS-1:0][COEF_W-1:0] coef;
        logic [TC_W-1:0]                   term_count;
    } pde_cfg_t;

    // Item state travelling from one Horner step to the next
    typedef struct packed {
        logic signed [PT_W-1:0]  x;
        logic [ORD_W-1:0]        n;
        logic signed [VAL_W-1:0] acc;
        logic                    sat;
    } pde_lane_t;

    // (j+n)!/j!, only meaningful for j+n below NUM_COEF
    function automatic logic [FF_W-1:0] pde_ffact(input int unsigned j, input int unsigned n);
        int unsigned f;
        f = 1;
        for (int unsigned k = 1; k <= NUM_COEF; k++)
        begin
            if (k <= n)
            begin
                f = f * (j + k);
            end
        end
        return FF_W'(f);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pde_cfg_regs.sv
// APB configuration registers: seven coefficients and the term count
`default_nettype none

module pde_cfg_regs
    import pde_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic      [CFG_DW-1:0] prdata,
    output logic                   pready,
    output pde_cfg_t               cfg
);

    logic [COEF_W-1:0] coef_reg [NUM_COEF];
    logic [TC_W-1:0]   term_count_reg;
    logic [IDX_W-1:0]  idx;
    logic              wr_en;

    assign idx    = paddr[CFG_AW-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEF; i++)
            begin
                coef_reg[i] <= '0;
            end
            term_count_reg <= '0;
        end
        else if (wr_en)
        begin
            if (idx == REG_TERM_COUNT)
            begin
                term_count_reg <= pwdata[TC_W-1:0];
            end
            else
            begin
                coef_reg[idx] <= pwdata;
            end
        end
    end

    // readback
    always_comb
    begin
        priority if (idx == REG_TERM_COUNT)
        begin
            prdata = CFG_DW'(term_count_reg);
        end
        else
        begin
            prdata = coef_reg[idx];
        end
    end

    // coefficient view, spare slot reads zero
    always_comb
    begin
        for (int i = 0; i < NUM_COEF; i++)
        begin
            cfg.coef[i] = coef_reg[i];
        end
        cfg.coef[COEF_SLOTS-1] = '0;
        cfg.term_count         = term_count_reg;
    end

endmodule

`default_nettype wire

FILE: rtl/core/pde_horner_step.sv
// One Horner step: acc*x rounded and clipped, plus scaled coefficient J, clipped
`default_nettype none

module pde_horner_step
    import pde_pkg::*;
#(
    parameter int J         = 0,
    parameter int FRAC_BITS = 16
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire pde_cfg_t  cfg,
    input  wire logic      vld_in,
    input  wire pde_lane_t lane_in,
    output logic           vld_out,
    output pde_lane_t      lane_out
);

    localparam logic [ORD_W:0] J_IDX = (ORD_W+1)'(J);

    localparam logic signed [PROD_W-1:0] RND_POS = PROD_W'(64'sd1) <<< (FRAC_BITS - 1);
    localparam logic signed [PROD_W-1:0] RND_NEG = RND_POS - PROD_W'(64'sd1);
    localparam logic signed [PROD_W-1:0] P_MAX   = PROD_W'(VAL_MAX);
    localparam logic signed [PROD_W-1:0] P_MIN   = PROD_W'(VAL_MIN);
    localparam logic signed [SUM_W-1:0]  S_MAX   = SUM_W'(VAL_MAX);
    localparam logic signed [SUM_W-1:0]  S_MIN   = SUM_W'(VAL_MIN);

    // stage 1: partial products and scaled coefficient
    logic                       v1_reg;
    logic signed [PT_W-1:0]     x1_reg;
    logic [ORD_W-1:0]           n1_reg;
    logic                       sat1_reg;
    logic signed [LO_PP_W-1:0]  pp_lo_reg, pp_lo_next;
    logic signed [HI_PP_W-1:0]  pp_hi_reg, pp_hi_next;
    logic                       neg_reg;
    logic signed [D_W-1:0]      d1_reg, d1_next;

    // stage 2: full product with rounding offset
    logic                       v2_reg;
    logic signed [PT_W-1:0]     x2_reg;
    logic [ORD_W-1:0]           n2_reg;
    logic                       sat2_reg;
    logic signed [PROD_W-1:0]   p_reg, p_next;
    logic signed [D_W-1:0]      d2_reg;

    // stage 3: scaled and clipped product
    logic                       v3_reg;
    logic signed [PT_W-1:0]     x3_reg;
    logic [ORD_W-1:0]           n3_reg;
    logic                       sat3_reg, sat3_next;
    logic signed [VAL_W-1:0]    m_reg, m_next;
    logic signed [D_W-1:0]      d3_reg;

    // stage 4: accumulate and clip
    logic                       v4_reg;
    pde_lane_t                  lane4_reg, lane4_next;

    logic signed [SPLIT:0]       a_lo;
    logic signed [VAL_W-SPLIT-1:0] a_hi;
    logic [ORD_W:0]             idx;
    logic                       use_term;
    logic signed [COEF_W-1:0]   coef_sel;
    logic [FF_W-1:0]            ff;
    logic signed [FF_W:0]       ff_s;
    logic signed [PROD_W-1:0]   r;
    logic signed [SUM_W-1:0]    s;

    // stage 1 logic
    always_comb
    begin
        a_lo = $signed({1'b0, lane_in.acc[SPLIT-1:0]});
        a_hi = $signed(lane_in.acc[VAL_W-1:SPLIT]);
        pp_lo_next = LO_PP_W'(a_lo) * LO_PP_W'(lane_in.x);
        pp_hi_next = HI_PP_W'(a_hi) * HI_PP_W'(lane_in.x);

        // coefficient j+n is live only below the term count
        idx      = J_IDX + {1'b0, lane_in.n};
        use_term = idx < {1'b0, cfg.term_count};
        coef_sel = $signed(cfg.coef[idx[IDX_W-1:0]]);
        ff       = '0;
        for (int i = 0; i < (1 << ORD_W); i++)
        begin
            if (lane_in.n == ORD_W'(i))
            begin
                ff = pde_ffact(J, i);
            end
        end
        ff_s    = $signed({1'b0, ff});
        d1_next = use_term ? D_W'(coef_sel) * D_W'(ff_s) : '0;
    end

    // stage 2 logic
    always_comb
    begin
        p_next = (PROD_W'(pp_hi_reg) <<< SPLIT) + PROD_W'(pp_lo_reg)
               + (neg_reg ? RND_NEG : RND_POS);
    end

    // stage 3 logic
    always_comb
    begin
        r         = p_reg >>> FRAC_BITS;
        sat3_next = sat2_reg;
        priority if (r > P_MAX)
        begin
            m_next    = VAL_MAX;
            sat3_next = 1'b1;
        end
        else if (r < P_MIN)
        begin
            m_next    = VAL_MIN;
            sat3_next = 1'b1;
        end
        else
        begin
            m_next = r[VAL_W-1:0];
        end
    end

    // stage 4 logic
    always_comb
    begin
        s            = SUM_W'(m_reg) + SUM_W'(d3_reg);
        lane4_next.x = x3_reg;
        lane4_next.n = n3_reg;
        lane4_next.sat = sat3_reg;
        priority if (s > S_MAX)
        begin
            lane4_next.acc = VAL_MAX;
            lane4_next.sat = 1'b1;
        end
        else if (s < S_MIN)
        begin
            lane4_next.acc = VAL_MIN;
            lane4_next.sat = 1'b1;
        end
        else
        begin
            lane4_next.acc = s[VAL_W-1:0];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= vld_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        x1_reg    <= lane_in.x;
        n1_reg    <= lane_in.n;
        sat1_reg  <= lane_in.sat;
        pp_lo_reg <= pp_lo_next;
        pp_hi_reg <= pp_hi_next;
        neg_reg   <= lane_in.acc[VAL_W-1] ^ lane_in.x[PT_W-1];
        d1_reg    <= d1_next;

        x2_reg    <= x1_reg;
        n2_reg    <= n1_reg;
        sat2_reg  <= sat1_reg;
        p_reg     <= p_next;
        d2_reg    <= d1_reg;

        x3_reg    <= x2_reg;
        n3_reg    <= n2_reg;
        sat3_reg  <= sat3_next;
        m_reg     <= m_next;
        d3_reg    <= d2_reg;

        lane4_reg <= lane4_next;
    end

    assign vld_out  = v4_reg;
    assign lane_out = lane4_reg;

endmodule

`default_nettype wire

FILE: rtl/core/polynomial_derivative_evaluator.sv
// Top level of the polynomial derivative evaluator
//
// Evaluates the n-th derivative of a configured polynomial (up to seven Q16.16
// coefficients) at one Q16.16 point per item, giving a saturated Q32.16 value.
// An item is taken whenever start is high and busy is low; busy is high only
// in the first cycle after reset, so one item can enter every cycle. Each
// result appears on result with done high for exactly one cycle, in input
// order, after passing through the Horner chain: MAX_TERMS steps of four
// stages each (partial products, product sum with rounding, scaling and
// clip, coefficient add and clip). Coefficients and term count are written
// over the APB port and must only change while no item is in flight.
`default_nettype none

module polynomial_derivative_evaluator
    import pde_pkg::*;
#(
    parameter int MAX_TERMS = 7,
    parameter int FRAC_BITS = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic      [CFG_DW-1:0] prdata,
    output logic                   pready,
    // items
    input  wire logic              start,
    output logic                   busy,
    input  wire pde_in_t           cmd,
    output logic                   done,
    output pde_out_t               result
);

    localparam logic [TC_W-1:0] MAX_T = TC_W'(MAX_TERMS);

    pde_cfg_t  cfg_raw;
    pde_cfg_t  cfg;
    logic      busy_reg;
    logic      vld  [MAX_TERMS+1];
    pde_lane_t lane [MAX_TERMS+1];

    pde_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg_raw)
    );

    // term count clamped to the terms this build supports
    always_comb
    begin
        cfg      = cfg_raw;
        if (cfg_raw.term_count > MAX_T)
        begin
            cfg.term_count = MAX_T;
        end
    end

    // busy for one cycle out of reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    assign busy = busy_reg;

    // chain entry: accumulator starts at zero
    assign vld[0]       = start && !busy_reg;
    assign lane[0].x    = cmd.point;
    assign lane[0].n    = cmd.derivative_order;
    assign lane[0].acc  = '0;
    assign lane[0].sat  = 1'b0;

    // Horner chain, highest coefficient first
    for (genvar k = 0; k < MAX_TERMS; k++)
    begin : g_step
        pde_horner_step #(
            .J         (MAX_TERMS - 1 - k),
            .FRAC_BITS (FRAC_BITS)
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .cfg      (cfg),
            .vld_in   (vld[k]),
            .lane_in  (lane[k]),
            .vld_out  (vld[k+1]),
            .lane_out (lane[k+1])
        );
    end

    assign done             = vld[MAX_TERMS];
    assign result.value     = lane[MAX_TERMS].acc;
    assign result.saturated = lane[MAX_TERMS].sat;

endmodule

`default_nettype wire

FILE: rtl/core/pde_checker.sv
// Port-level checker for the polynomial derivative evaluator, with its bind
`default_nettype none

`include "polynomial_derivative_evaluator_assert.svh"

module pde_checker
    import pde_pkg::*;
#(
    parameter int MAX_TERMS = 7
)
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              psel,
    input wire logic              penable,
    input wire logic              pwrite,
    input wire logic [CFG_AW-1:0] paddr,
    input wire logic [CFG_DW-1:0] pwdata,
    input wire logic [CFG_DW-1:0] prdata,
    input wire logic              pready,
    input wire logic              start,
    input wire logic              busy,
    input wire pde_in_t           cmd,
    input wire logic              done,
    input wire pde_out_t          result
);

    localparam int               LAT     = STEP_STAGES * MAX_TERMS;
    localparam logic [ORD_W-1:0] ORD_TOP = '1;

    logic take;
    logic take_top;
    logic out_zero;
    logic coef_wr;

    assign take     = start && !busy;
    assign take_top = take && cmd.derivative_order == ORD_TOP;
    assign out_zero = result.value == '0 && !result.saturated;
    assign coef_wr  = psel && penable && pwrite && pready
                      && paddr[CFG_AW-1:2] != REG_TERM_COUNT;

    // every taken item comes back after the fixed latency
    `PDE_ASSERT_NOW(a_item_returns, take, ##LAT done)

    // no result without an item taken the latency earlier
    `PDE_ASSERT_NOW(a_no_stray_result, done, $past(take, LAT))

    // the top order is never below the term count: zero, not saturated
    `PDE_ASSERT_NOW(a_top_order_zero, take_top, ##LAT out_zero)

    // a coefficient write reads back on the next cycle
    `PDE_ASSERT_NEXT(a_coef_readback, coef_wr, ($stable(paddr) |-> prdata == $past(pwdata)))

endmodule

bind polynomial_derivative_evaluator pde_checker #(
    .MAX_TERMS (MAX_TERMS)
) u_pde_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .start   (start),
    .busy    (busy),
    .cmd     (cmd),
    .done    (done),
    .result  (result)
);

`default_nettype wire
